// ----- rtl/core/md5_hash_stream_core_macros.svh -----
// Assertion macros used by the checker file of the MD5 stream core.
`ifndef MD5_HASH_STREAM_CORE_MACROS_SVH
`define MD5_HASH_STREAM_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define MD5_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MD5_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/md5_pkg.sv -----
// Package with the shared types, constants and tables of the MD5 stream core.
package md5_pkg;
  localparam int QueueDepth = 4;
  localparam int QueueAw = 2;

  // Command passed from the front end to the back end.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       end_of_message;
  } md5_cmd_t;

  // Queue handshake between front end and back end.
  typedef struct packed {
    logic     valid;
    md5_cmd_t cmd;
  } md5_q_out_t;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  function automatic logic [31:0] sine_k(input logic [5:0] t);
    logic [31:0] k;
    begin
      case (t)
        6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
        6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
        6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
        6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
        6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
        6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
        6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
        6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
        6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
        6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
        6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
        6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
        6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
        6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
        6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
        6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
        6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
        6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
        6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
        6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
        6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
        6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
        default: k = 32'h0;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] i);
    logic [4:0] r;
    begin
      case (i)
        4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
        4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
        4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
        4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; 4'd15: r = 5'd21;
        default: r = 5'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction
endpackage

// ----- rtl/core/md5_front.sv -----
// Front end: accepts input transactions, drops empty ones and queues the rest.
module md5_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_has_data,
  input  logic              in_end_of_message,
  input  logic              q_pop,
  output md5_pkg::md5_q_out_t q_out
);
  import md5_pkg::*;

  md5_cmd_t             fifo_r [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QueueAw:0]     count_r, count_nxt;
  logic                 push, pop;

  assign in_tready = (count_r != QueueAw'(0) + (QueueAw+1)'(QueueDepth));
  // Items that carry neither a byte nor an end mark change nothing.
  assign push = in_tvalid && in_tready && (in_has_data || in_end_of_message);
  assign pop  = q_pop && (count_r != '0);

  assign q_out.valid = (count_r != '0);
  assign q_out.cmd   = fifo_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= '{data_byte: in_data_byte, has_data: in_has_data,
                            end_of_message: in_end_of_message};
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end
endmodule

// ----- rtl/core/md5_back.sv -----
// Back end: block buffer, padding sequencer and one-round-per-cycle compression.
module md5_back (
  input  logic                clk,
  input  logic                rst_n,
  input  md5_pkg::md5_q_out_t q_in,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [127:0]        out_tdata
);
  import md5_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StComp  = 3'd1;
  localparam logic [2:0] StPad   = 3'd2;
  localparam logic [2:0] StLen   = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0]  state_r;
  logic [31:0] mem_r [16];
  logic [5:0]  fill_r;
  logic [63:0] bits_r, len_r;
  logic [31:0] h_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  t_r;
  logic        pad_r;      // 1 while the 0x80 marker byte is still to be written
  logic        fin_r;      // 1 while the current message is being finished
  logic [2:0]  len_idx_r;
  logic        ovalid_r, ovalid_nxt;
  logic [127:0] odata_r;

  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [3:0]  w_idx;
  logic [31:0] f_val, sum, rot, m_word;
  logic [1:0]  grp;
  logic [4:0]  sh;

  assign grp = t_r[5:4];
  always_comb begin
    case (grp)
      2'd0: begin f_val = (b_r & c_r) | (~b_r & d_r); w_idx = t_r[3:0]; end
      2'd1: begin
        f_val = (b_r & d_r) | (c_r & ~d_r);
        w_idx = 4'(t_r[3:0] * 4'd5 + 4'd1);
      end
      2'd2: begin
        f_val = b_r ^ c_r ^ d_r;
        w_idx = 4'(t_r[3:0] * 4'd3 + 4'd5);
      end
      default: begin f_val = c_r ^ (b_r | ~d_r); w_idx = 4'(t_r[3:0] * 4'd7); end
    endcase
  end
  assign m_word = mem_r[w_idx];
  assign sum = a_r + f_val + sine_k(t_r) + m_word;
  assign sh  = rot_amount({grp, t_r[1:0]});
  assign rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));

  assign q_pop = (state_r == StIdle) && q_in.valid;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    if (state_r == StOut && (!ovalid_r || out_tready)) ovalid_nxt = 1'b1;
  end

  always_comb begin
    wr_en = 1'b0;
    wr_byte = 8'h00;
    case (state_r)
      StIdle: begin
        if (q_in.valid && q_in.cmd.has_data) begin
          wr_en = 1'b1;
          wr_byte = q_in.cmd.data_byte;
        end else if (q_in.valid) begin
          wr_en = 1'b1;
          wr_byte = 8'h80;
        end
      end
      StPad: begin wr_en = 1'b1; wr_byte = pad_r ? 8'h80 : 8'h00; end
      StLen: begin wr_en = 1'b1; wr_byte = len_r[8*len_idx_r +: 8]; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[fill_r[5:2]][8*fill_r[1:0] +: 8] <= wr_byte;
    if (!rst_n) begin
      state_r <= StIdle;
      fill_r <= '0;
      bits_r <= '0;
      h_r[0] <= InitA; h_r[1] <= InitB; h_r[2] <= InitC; h_r[3] <= InitD;
      t_r <= '0;
      pad_r <= 1'b0;
      fin_r <= 1'b0;
      len_idx_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      case (state_r)
        StIdle: begin
          if (q_in.valid) begin
            fin_r <= q_in.cmd.end_of_message;
            if (q_in.cmd.has_data) begin
              fill_r <= fill_r + 1'b1;
              bits_r <= bits_r + 64'd8;
              len_r <= bits_r + 64'd8;
              pad_r <= q_in.cmd.end_of_message;
              if (fill_r == 6'd63) begin
                state_r <= StComp;
              end else if (q_in.cmd.end_of_message) begin
                state_r <= StPad;
              end
            end else begin
              // End without a byte: the 0x80 marker goes in right here.
              len_r <= bits_r;
              pad_r <= 1'b0;
              fill_r <= fill_r + 1'b1;
              if (fill_r == 6'd63) state_r <= StComp;
              else if (fill_r == 6'd55) state_r <= StLen;
              else state_r <= StPad;
            end
            a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
            t_r <= '0;
            len_idx_r <= '0;
          end
        end
        StPad: begin
          fill_r <= fill_r + 1'b1;
          pad_r <= 1'b0;
          a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
          t_r <= '0;
          if (fill_r == 6'd63) state_r <= StComp;
          else if (fill_r == 6'd55) state_r <= StLen;
        end
        StLen: begin
          fill_r <= fill_r + 1'b1;
          a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
          t_r <= '0;
          // The index stays at seven once the last length byte is written.
          if (len_idx_r == 3'd7) begin
            state_r <= StComp;
            pad_r <= 1'b0;
          end else begin
            len_idx_r <= len_idx_r + 1'b1;
          end
        end
        StComp: begin
          if (t_r == 6'd63) begin
            h_r[0] <= h_r[0] + d_r;
            h_r[1] <= h_r[1] + b_r + rot;
            h_r[2] <= h_r[2] + b_r;
            h_r[3] <= h_r[3] + c_r;
            a_r <= h_r[0] + d_r; b_r <= h_r[1] + b_r + rot;
            c_r <= h_r[2] + b_r; d_r <= h_r[3] + c_r;
            t_r <= '0;
            // A finished message goes out once its length block is done.
            if (!fin_r) state_r <= StIdle;
            else if (len_idx_r == 3'd7) state_r <= StOut;
            else state_r <= StPad;
          end else begin
            a_r <= d_r; d_r <= c_r; c_r <= b_r;
            b_r <= b_r + rot;
            t_r <= t_r + 1'b1;
          end
        end
        StOut: begin
          if (!ovalid_r || out_tready) begin
            odata_r <= {bswap32(h_r[0]), bswap32(h_r[1]),
                        bswap32(h_r[2]), bswap32(h_r[3])};
            h_r[0] <= InitA; h_r[1] <= InitB; h_r[2] <= InitC; h_r[3] <= InitD;
            bits_r <= '0;
            fill_r <= '0;
            fin_r <= 1'b0;
            len_idx_r <= '0;
            state_r <= StIdle;
          end
        end
        default: state_r <= StIdle;
      endcase
    end
  end
endmodule

// ----- rtl/core/md5_hash_stream_core.sv -----
// Top level of the MD5 stream core: front-end queue and compression back end.
// Bytes are taken at one per cycle while the back end is idle; each full block then stalls
// the input for its compression rounds. End of message adds padding and length bytes plus
// one or two compressed blocks before the digest is presented.
// Reset (synchronous, active low) loads the initial chaining words and clears counts.
module md5_hash_stream_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] has_data
  input  logic         in_tlast,   // end_of_message
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // [63:0] digest_high, [127:64] digest_low
);
  import md5_pkg::*;

  md5_q_out_t q_out;
  logic       q_pop;
  logic [127:0] dig;

  md5_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_data_byte(in_tdata), .in_has_data(in_tuser),
    .in_end_of_message(in_tlast), .q_pop, .q_out
  );

  md5_back u_back (
    .clk, .rst_n, .q_in(q_out), .q_pop, .out_tvalid, .out_tready,
    .out_tdata(dig)
  );

  assign out_tdata = {dig[63:0], dig[127:64]};
endmodule

// ----- rtl/core/md5_checker.sv -----
// Port checker for the MD5 stream core, bound to the top level.
`include "md5_hash_stream_core_macros.svh"
module md5_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);
  `MD5_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `MD5_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `MD5_ASSERT_IMP(a_out_known, clk, rst_n, out_tvalid, !$isunknown(out_tdata))
  `MD5_ASSERT_IMP(a_in_ready_known, clk, rst_n, in_tvalid, !$isunknown(in_tready))
endmodule

bind md5_hash_stream_core md5_checker u_md5_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
